>>> src/sts_pkg.sv
// ----------------------------------------------------------------------------
// sts_pkg: shared types and constants
// Sum width, rank limits and the union-find status group.
// ----------------------------------------------------------------------------
`default_nettype none
package sts_pkg;

  localparam int SUM_W = 26;
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
  localparam int RANK_W = 4;
  localparam logic [RANK_W-1:0] RANK_MAX = {RANK_W{1'b1}};

  typedef struct packed {
    logic idle;
    logic done;
    logic merged;
  } dsu_stat_t;

endpackage
`default_nettype wire

>>> src/sts_edge_store.sv
// ----------------------------------------------------------------------------
// sts_edge_store: edge memory with in-place insertion sort
// Edges are written while idle; one compare unit sorts them by weight.
// ----------------------------------------------------------------------------
`default_nettype none
module sts_edge_store #(
  parameter int DEPTH = 1024,
  parameter int AW = 10,
  parameter int CW = 11,
  parameter int DW = 32,
  parameter int KW = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data,
  input  wire logic [CW-1:0] cnt,
  input  wire logic          sort_start,
  output logic               busy,
  input  wire logic [AW-1:0] rd_addr,
  output logic [DW-1:0]      rd_data
);
  import sts_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_NEXT, S_KEY, S_CMP, S_PUT} st_t;

  st_t st_r, st_nxt;
  logic [CW-1:0] i_r, i_nxt, j_r, j_nxt;
  logic [CW-1:0] im1, jm2;
  logic [DW-1:0] key_r, key_nxt;
  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_q;
  logic          mem_we;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [DW-1:0] mem_wd;

  assign im1 = i_r - 1'b1;
  assign jm2 = j_r - CW'(2);

  always_comb begin
    st_nxt  = st_r;
    i_nxt   = i_r;
    j_nxt   = j_r;
    key_nxt = key_r;
    mem_we  = 1'b0;
    mem_wa  = wr_addr;
    mem_wd  = wr_data;
    mem_ra  = rd_addr;
    case (st_r)
      S_IDLE: begin
        mem_we = wr_en;
        if (sort_start) begin
          i_nxt  = CW'(1);
          st_nxt = S_NEXT;
        end
      end
      S_NEXT: begin
        if (i_r >= cnt) begin
          st_nxt = S_IDLE;
        end else begin
          mem_ra = i_r[AW-1:0];
          st_nxt = S_KEY;
        end
      end
      S_KEY: begin
        key_nxt = rd_q;
        j_nxt   = i_r;
        mem_ra  = im1[AW-1:0];
        st_nxt  = S_CMP;
      end
      S_CMP: begin
        mem_we = 1'b1;
        mem_wa = j_r[AW-1:0];
        if (rd_q[KW-1:0] > key_r[KW-1:0]) begin
          // shift the heavier edge up one slot
          mem_wd = rd_q;
          j_nxt  = j_r - 1'b1;
          if (j_r == CW'(1)) begin
            st_nxt = S_PUT;
          end else begin
            mem_ra = jm2[AW-1:0];
          end
        end else begin
          mem_wd = key_r;
          i_nxt  = i_r + 1'b1;
          st_nxt = S_NEXT;
        end
      end
      S_PUT: begin
        mem_we = 1'b1;
        mem_wa = j_r[AW-1:0];
        mem_wd = key_r;
        i_nxt  = i_r + 1'b1;
        st_nxt = S_NEXT;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      st_r <= st_nxt;
    end
    i_r   <= i_nxt;
    j_r   <= j_nxt;
    key_r <= key_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_q <= mem[mem_ra];
  end

  assign busy    = (st_r != S_IDLE);
  assign rd_data = rd_q;

endmodule
`default_nettype wire

>>> src/sts_dsu.sv
// ----------------------------------------------------------------------------
// sts_dsu: union-find store
// Parent and rank memories, clearing sweep, find with path compression,
// union by rank.
// ----------------------------------------------------------------------------
`default_nettype none
module sts_dsu #(
  parameter int N = 256,
  parameter int NW = 8
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           clr_start,
  input  wire logic           op_start,
  input  wire logic [NW-1:0]  end_a,
  input  wire logic [NW-1:0]  end_b,
  output sts_pkg::dsu_stat_t  stat
);
  import sts_pkg::*;

  typedef enum logic [3:0] {
    D_IDLE, D_CLR, D_FRD, D_FCK, D_CRD, D_CCK, D_RK0, D_RK1, D_RK2, D_DONE
  } st_t;

  st_t st_r, st_nxt;
  logic [NW-1:0] k_r, k_nxt, x_r, x_nxt, cur_r, cur_nxt, root_r, root_nxt;
  logic [NW-1:0] roota_r, roota_nxt, eb_r, eb_nxt;
  logic [RANK_W-1:0] rka_r, rka_nxt;
  logic side_r, side_nxt, merged_r, merged_nxt;

  logic [NW-1:0]     par [N];
  logic [RANK_W-1:0] rnk [N];
  logic [NW-1:0]     p_q, p_wa, p_wd, p_ra, r_wa, r_ra;
  logic [RANK_W-1:0] r_q, r_wd;
  logic              p_we, r_we;

  always_comb begin
    st_nxt     = st_r;
    k_nxt      = k_r;
    x_nxt      = x_r;
    cur_nxt    = cur_r;
    root_nxt   = root_r;
    roota_nxt  = roota_r;
    eb_nxt     = eb_r;
    rka_nxt    = rka_r;
    side_nxt   = side_r;
    merged_nxt = merged_r;
    p_we = 1'b0; p_wa = cur_r; p_wd = root_r; p_ra = cur_r;
    r_we = 1'b0; r_wa = root_r; r_wd = '0;   r_ra = roota_r;
    case (st_r)
      D_IDLE: begin
        if (clr_start) begin
          k_nxt  = '0;
          st_nxt = D_CLR;
        end else if (op_start) begin
          side_nxt = 1'b0;
          x_nxt    = end_a;
          cur_nxt  = end_a;
          eb_nxt   = end_b;
          st_nxt   = D_FRD;
        end
      end
      D_CLR: begin
        p_we = 1'b1; p_wa = k_r; p_wd = k_r;
        r_we = 1'b1; r_wa = k_r; r_wd = '0;
        k_nxt = k_r + 1'b1;
        if (k_r == NW'(N - 1)) begin
          st_nxt = D_IDLE;
        end
      end
      D_FRD: st_nxt = D_FCK;
      D_FCK: begin
        if (p_q == cur_r) begin
          root_nxt = cur_r;
          cur_nxt  = x_r;
          st_nxt   = D_CRD;
        end else begin
          cur_nxt = p_q;
          p_ra    = p_q;
        end
      end
      D_CRD: st_nxt = D_CCK;
      D_CCK: begin
        if (p_q == root_r) begin
          if (!side_r) begin
            roota_nxt = root_r;
            side_nxt  = 1'b1;
            x_nxt     = eb_r;
            cur_nxt   = eb_r;
            st_nxt    = D_FRD;
          end else if (roota_r == root_r) begin
            merged_nxt = 1'b0;
            st_nxt     = D_DONE;
          end else begin
            st_nxt = D_RK0;
          end
        end else begin
          // point this node straight at the root, then follow old parent
          p_we    = 1'b1;
          cur_nxt = p_q;
          p_ra    = p_q;
        end
      end
      D_RK0: st_nxt = D_RK1;
      D_RK1: begin
        rka_nxt = r_q;
        r_ra    = root_r;
        st_nxt  = D_RK2;
      end
      D_RK2: begin
        merged_nxt = 1'b1;
        p_we = 1'b1;
        if (rka_r > r_q) begin
          p_wa = root_r;
          p_wd = roota_r;
        end else begin
          p_wa = roota_r;
          p_wd = root_r;
          if (rka_r == r_q && r_q < RANK_MAX) begin
            r_we = 1'b1;
            r_wd = r_q + 1'b1;
          end
        end
        st_nxt = D_DONE;
      end
      D_DONE: st_nxt = D_IDLE;
      default: st_nxt = D_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= D_IDLE;
      merged_r <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      merged_r <= merged_nxt;
    end
    k_r     <= k_nxt;
    x_r     <= x_nxt;
    cur_r   <= cur_nxt;
    root_r  <= root_nxt;
    roota_r <= roota_nxt;
    eb_r    <= eb_nxt;
    rka_r   <= rka_nxt;
    side_r  <= side_nxt;
  end

  always_ff @(posedge clk) begin
    if (p_we) begin
      par[p_wa] <= p_wd;
    end
    p_q <= par[p_ra];
  end

  always_ff @(posedge clk) begin
    if (r_we) begin
      rnk[r_wa] <= r_wd;
    end
    r_q <= rnk[r_ra];
  end

  assign stat.idle   = (st_r == D_IDLE);
  assign stat.done   = (st_r == D_DONE);
  assign stat.merged = merged_r;

endmodule
`default_nettype wire

>>> src/spanning_tree_savings.sv
// ----------------------------------------------------------------------------
// spanning_tree_savings: minimum spanning tree cost and savings
// Loads a graph's edges, then runs Kruskal's method over a union-find store.
// ----------------------------------------------------------------------------
// Edges load at one transfer per cycle. After the transfer with tlast set the
// block stops taking input: the edge memory is insertion-sorted by weight
// while the union-find store runs its clearing sweep over all MAX_NODES
// entries; then for each edge in sorted order both ends are found, with path
// compression, and the two sets are joined by rank when they differ. One
// result per graph, held in an output register so loading of the next graph
// may start while it waits.
`default_nettype none
module spanning_tree_savings #(
  parameter int MAX_NODES   = 256,
  parameter int MAX_EDGES   = 1024,
  parameter int WEIGHT_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // end_a[7:0], end_b[15:8], weight[31:16]
  input  wire logic        in_tlast,   // last_item
  input  wire logic        in_tuser,   // no_edge
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata,  // saved_weight[25:0], tree_weight[51:26]
  output logic             out_tuser,  // bad_edge
  input  wire logic        cfg_wr_en,
  input  wire logic [8:0]  cfg_wr_data
);
  import sts_pkg::*;

  localparam int NW    = $clog2(MAX_NODES);
  localparam int AW    = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int CW    = $clog2(MAX_EDGES + 1);
  localparam int DW    = WEIGHT_BITS + 2 * NW;
  localparam int ACC_W = ((WEIGHT_BITS > SUM_W) ? WEIGHT_BITS : SUM_W) + 1;

  typedef enum logic [2:0] {
    T_LOAD, T_START, T_SORT, T_RD, T_EDGE, T_WAIT, T_OUT
  } state_t;

  state_t st_r, st_nxt;
  logic [8:0] nodes_r;
  logic [CW-1:0] cnt_r, cnt_nxt, k_r, k_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt, tree_r, tree_nxt;
  logic err_r, err_nxt;
  logic [WEIGHT_BITS-1:0] ew_r, ew_nxt;
  logic out_tvalid_r, out_tvalid_nxt;
  logic [SUM_W-1:0] saved_r, treeo_r;
  logic bad_r, out_load;

  logic [16:0] a17, b17, nlim;
  logic [31:0] wfull;
  logic [WEIGHT_BITS-1:0] w_in;
  logic [ACC_W-1:0] ld_acc, tr_acc;
  logic accept, bad, st_we, sort_start, clr_start, op_start, sort_busy;
  logic [DW-1:0] st_wd, rd_data;
  logic [SUM_W-1:0] saved_val;
  dsu_stat_t dsu_stat;

  assign in_tready = (st_r == T_LOAD);
  assign accept    = in_tvalid && in_tready;
  assign a17   = {9'b0, in_tdata[7:0]};
  assign b17   = {9'b0, in_tdata[15:8]};
  assign nlim  = (17'(nodes_r) > 17'(MAX_NODES)) ? 17'(MAX_NODES) : 17'(nodes_r);
  assign bad   = (a17 >= nlim) || (b17 >= nlim);
  assign wfull = {16'b0, in_tdata[31:16]};
  assign w_in  = wfull[WEIGHT_BITS-1:0];
  assign st_we = accept && !in_tuser && !bad && (cnt_r < CW'(MAX_EDGES));
  assign st_wd = {a17[NW-1:0], b17[NW-1:0], w_in};
  assign ld_acc = ACC_W'(sum_r) + ACC_W'(w_in);
  assign tr_acc = ACC_W'(tree_r) + ACC_W'(ew_r);
  assign saved_val = (sum_r >= tree_r) ? (sum_r - tree_r) : '0;

  always_comb begin
    st_nxt         = st_r;
    cnt_nxt        = cnt_r;
    sum_nxt        = sum_r;
    err_nxt        = err_r;
    k_nxt          = k_r;
    tree_nxt       = tree_r;
    ew_nxt         = ew_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_load       = 1'b0;
    sort_start     = 1'b0;
    clr_start      = 1'b0;
    op_start       = 1'b0;
    case (st_r)
      T_LOAD: begin
        if (accept) begin
          if (!in_tuser && bad) begin
            err_nxt = 1'b1;
          end
          if (st_we) begin
            cnt_nxt = cnt_r + 1'b1;
            sum_nxt = (ld_acc > ACC_W'(SUM_MAX)) ? SUM_MAX : ld_acc[SUM_W-1:0];
          end
          if (in_tlast) begin
            st_nxt = T_START;
          end
        end
      end
      T_START: begin
        sort_start = 1'b1;
        clr_start  = 1'b1;
        k_nxt      = '0;
        tree_nxt   = '0;
        st_nxt     = T_SORT;
      end
      T_SORT: begin
        if (!sort_busy && dsu_stat.idle) begin
          st_nxt = T_RD;
        end
      end
      T_RD: begin
        st_nxt = (k_r == cnt_r) ? T_OUT : T_EDGE;
      end
      T_EDGE: begin
        op_start = 1'b1;
        ew_nxt   = rd_data[WEIGHT_BITS-1:0];
        st_nxt   = T_WAIT;
      end
      T_WAIT: begin
        if (dsu_stat.done) begin
          if (dsu_stat.merged) begin
            tree_nxt = (tr_acc > ACC_W'(SUM_MAX)) ? SUM_MAX : tr_acc[SUM_W-1:0];
          end
          k_nxt  = k_r + 1'b1;
          st_nxt = T_RD;
        end
      end
      T_OUT: begin
        if (!out_tvalid_r || out_tready) begin
          out_load       = 1'b1;
          out_tvalid_nxt = 1'b1;
          cnt_nxt        = '0;
          sum_nxt        = '0;
          err_nxt        = 1'b0;
          st_nxt         = T_LOAD;
        end
      end
      default: st_nxt = T_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= T_LOAD;
      nodes_r      <= 9'd256;
      cnt_r        <= '0;
      sum_r        <= '0;
      err_r        <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      st_r         <= st_nxt;
      cnt_r        <= cnt_nxt;
      sum_r        <= sum_nxt;
      err_r        <= err_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_wr_en) begin
        nodes_r <= cfg_wr_data;
      end
    end
    k_r    <= k_nxt;
    tree_r <= tree_nxt;
    ew_r   <= ew_nxt;
    if (out_load) begin
      saved_r <= saved_val;
      treeo_r <= tree_r;
      bad_r   <= err_r;
    end
  end

  sts_edge_store #(
    .DEPTH(MAX_EDGES), .AW(AW), .CW(CW), .DW(DW), .KW(WEIGHT_BITS)
  ) u_store (
    .clk(clk), .rst_n(rst_n),
    .wr_en(st_we), .wr_addr(cnt_r[AW-1:0]), .wr_data(st_wd),
    .cnt(cnt_r), .sort_start(sort_start), .busy(sort_busy),
    .rd_addr(k_r[AW-1:0]), .rd_data(rd_data)
  );

  sts_dsu #(.N(MAX_NODES), .NW(NW)) u_dsu (
    .clk(clk), .rst_n(rst_n),
    .clr_start(clr_start), .op_start(op_start),
    .end_a(rd_data[DW-1 -: NW]), .end_b(rd_data[WEIGHT_BITS +: NW]),
    .stat(dsu_stat)
  );

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {4'b0, treeo_r, saved_r};
  assign out_tuser  = bad_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_EDGES)) else $error("edge count past capacity");
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(st_r == T_OUT)) else $error("result without finish");
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (!sort_busy && dsu_stat.idle)) else $error("load while busy");
  a_dsu_done: assert property (@(posedge clk) disable iff (!rst_n)
    dsu_stat.done |-> (st_r == T_WAIT)) else $error("unexpected union done");

endmodule
`default_nettype wire

>>> test/spanning_tree_savings_test.sv
// ----------------------------------------------------------------------------
// spanning_tree_savings_test: self-checking bench for the MST savings block
// Streams edge sets at several node counts. A local Kruskal predictor with
// union-find computes each graph's tree weight, savings and error flag.
// Each result transfer is compared with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module spanning_tree_savings_test;
  import sts_pkg::*;

  localparam int NODES = 256;
  localparam int EDGES = 1024;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int DRAIN_CYCLES = 400;

  typedef struct {
    logic [7:0]  end_a;
    logic [7:0]  end_b;
    logic [15:0] weight;
    logic        no_edge;
    logic        last_item;
  } edge_item_t;

  typedef struct {
    logic [SUM_W-1:0] saved;
    logic [SUM_W-1:0] tree;
    logic             bad;
  } mst_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // end_a[7:0], end_b[15:8], weight[31:16]
  logic        in_tlast;   // last_item
  logic        in_tuser;   // no_edge
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;  // saved_weight[25:0], tree_weight[51:26]
  logic        out_tuser;  // bad_edge
  logic        cfg_wr_en;
  logic [8:0]  cfg_wr_data;

  spanning_tree_savings u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tlast(in_tlast), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  edge_item_t  edge_q[$];
  mst_result_t mst_q[$];
  bit          failed;
  bit          calm;
  bit          hold_go;
  bit          in_taken;
  int          in_gap;
  int          out_gap;
  int          hold_cnt;
  int          cycles;

  // predictor state
  logic [8:0]       node_count;
  logic [15:0]      st_w[EDGES];
  logic [7:0]       st_a[EDGES];
  logic [7:0]       st_b[EDGES];
  int               n_loaded;
  logic [SUM_W-1:0] sum_acc;
  logic             err_acc;
  int               parent[NODES];
  int               rnk[NODES];

  function automatic int root_of(int x);
    int r;
    int nx;
    r = x;
    while (parent[r] != r) r = parent[r];
    while (parent[x] != r) begin
      nx = parent[x];
      parent[x] = r;
      x = nx;
    end
    return r;
  endfunction

  function automatic logic [SUM_W-1:0] tree_cost();
    longint cost;
    int i, j, x, y;
    logic [15:0] w;
    logic [7:0] a, b;
    cost = 0;
    for (i = 0; i < NODES; i++) begin
      parent[i] = i;
      rnk[i] = 0;
    end
    for (i = 1; i < n_loaded; i++) begin
      w = st_w[i]; a = st_a[i]; b = st_b[i];
      j = i;
      while (j > 0 && st_w[j-1] > w) begin
        st_w[j] = st_w[j-1]; st_a[j] = st_a[j-1]; st_b[j] = st_b[j-1];
        j--;
      end
      st_w[j] = w; st_a[j] = a; st_b[j] = b;
    end
    for (i = 0; i < n_loaded; i++) begin
      x = root_of(st_a[i]);
      y = root_of(st_b[i]);
      if (x != y) begin
        cost += st_w[i];
        if (rnk[x] > rnk[y]) begin
          parent[y] = x;
        end else begin
          parent[x] = y;
          if (rnk[x] == rnk[y] && rnk[y] < RANK_MAX) rnk[y]++;
        end
      end
    end
    return (cost > SUM_MAX) ? SUM_MAX : cost[SUM_W-1:0];
  endfunction

  task automatic predict_edge(edge_item_t it);
    int lim;
    longint s;
    mst_result_t r;
    lim = (node_count < NODES) ? node_count : NODES;
    if (!it.no_edge) begin
      if (it.end_a >= lim || it.end_b >= lim) begin
        err_acc = 1'b1;
      end else if (n_loaded < EDGES) begin
        st_w[n_loaded] = it.weight;
        st_a[n_loaded] = it.end_a;
        st_b[n_loaded] = it.end_b;
        n_loaded++;
        s = sum_acc + it.weight;
        sum_acc = (s > SUM_MAX) ? SUM_MAX : s[SUM_W-1:0];
      end
    end
    if (it.last_item) begin
      r.tree = tree_cost();
      r.saved = (sum_acc >= r.tree) ? sum_acc - r.tree : '0;
      r.bad = err_acc;
      mst_q = {mst_q, r};
      n_loaded = 0;
      sum_acc = '0;
      err_acc = 1'b0;
    end
  endtask

  // sampling side: input transfers feed the predictor, results are checked
  always @(posedge clk) begin
    edge_item_t it;
    mst_result_t e;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
    if (rst_n && in_tvalid && in_tready) begin
      it.end_a = in_tdata[7:0];
      it.end_b = in_tdata[15:8];
      it.weight = in_tdata[31:16];
      it.no_edge = in_tuser;
      it.last_item = in_tlast;
      predict_edge(it);
      in_taken = 1'b1;
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (mst_q.size() == 0) begin
        $display("%0t: unexpected result saved=%0d tree=%0d bad=%0b", $realtime,
                 out_tdata[25:0], out_tdata[51:26], out_tuser);
        failed = 1'b1;
      end else begin
        e = mst_q.pop_front();
        if (out_tdata[25:0] !== e.saved) begin
          $display("%0t: saved_weight expected %0d actual %0d", $realtime, e.saved,
                   out_tdata[25:0]);
          failed = 1'b1;
        end
        if (out_tdata[51:26] !== e.tree) begin
          $display("%0t: tree_weight expected %0d actual %0d", $realtime, e.tree,
                   out_tdata[51:26]);
          failed = 1'b1;
        end
        if (out_tuser !== e.bad) begin
          $display("%0t: bad_edge expected %0b actual %0b", $realtime, e.bad, out_tuser);
          failed = 1'b1;
        end
      end
    end
  end

  // sender: valid stays up until the transfer happens
  always @(negedge clk) begin
    bit free;
    if (rst_n) begin
      free = !in_tvalid || in_taken;
      if (in_taken) begin
        void'(edge_q.pop_front());
        in_taken = 1'b0;
      end
      if (free && !calm && in_gap == 0 && $urandom_range(0, 9) == 0)
        in_gap = $urandom_range(1, 11);
      if (free && in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (edge_q.size() != 0) begin
        in_tdata <= {edge_q[0].weight, edge_q[0].end_b, edge_q[0].end_a};
        in_tuser <= edge_q[0].no_edge;
        in_tlast <= edge_q[0].last_item;
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus one long hold-off
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_go) begin
        hold_go = 1'b0;
        hold_cnt = 3000;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_tready <= 1'b0;
      end else if (!calm && out_gap == 0 && $urandom_range(0, 7) == 0) begin
        out_gap = $urandom_range(1, 11);
        out_tready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_tready <= (out_gap == 0);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic push_edge(int a, int b, int w, bit ne, bit last);
    edge_item_t it;
    it.end_a = 8'(a); it.end_b = 8'(b); it.weight = 16'(w);
    it.no_edge = ne; it.last_item = last;
    edge_q = {edge_q, it};
  endtask

  task automatic wait_idle();
    @(posedge clk);
    while (edge_q.size() != 0 || in_tvalid || mst_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_nodes(int n);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= 9'(n);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    node_count = 9'(n);
  endtask

  // one random graph; mostly in-range edges, some noise
  task automatic random_graph(int n_edges);
    int lim, i, a, b, w;
    bit ties;
    lim = (node_count < NODES) ? node_count : NODES;
    ties = $urandom_range(0, 1);
    for (i = 0; i < n_edges; i++) begin
      if (lim > 0 && $urandom_range(0, 99) < 88) begin
        a = $urandom_range(0, lim - 1);
        b = $urandom_range(0, lim - 1);
      end else begin
        a = $urandom_range(0, 255);
        b = $urandom_range(0, 255);
      end
      w = ties ? $urandom_range(0, 7) : $urandom_range(0, 65535);
      if ($urandom_range(0, 19) == 0)
        push_edge(a, b, w, 1'b1, 1'b0);
      else
        push_edge(a, b, w, 1'b0, i == n_edges - 1);
    end
    if ($urandom_range(0, 3) == 0 || n_edges == 0)
      push_edge($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 65535),
                1'b1, 1'b1);
    else if (edge_q.size() != 0 && !edge_q[$].last_item)
      push_edge(0, 0, 0, 1'b1, 1'b1);
  endtask

  initial begin
    int ph, i, n, total;
    int counts[8] = '{256, 2, 511, 1, 17, 0, 300, 64};
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    in_tuser = 1'b0;
    out_tready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    node_count = 9'd256;
    n_loaded = 0;
    sum_acc = '0;
    err_acc = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: extremes, self loop, empty graph, parallel edges at reset count
    push_edge(0, 255, 65535, 1'b0, 1'b0);
    push_edge(255, 0, 0, 1'b0, 1'b0);
    push_edge(3, 3, 7, 1'b0, 1'b0);
    push_edge(0, 255, 1, 1'b0, 1'b1);
    push_edge(255, 255, 65535, 1'b1, 1'b1);
    push_edge(10, 11, 5, 1'b0, 1'b0);
    push_edge(11, 12, 5, 1'b0, 1'b0);
    push_edge(10, 12, 5, 1'b0, 1'b1);
    wait_idle();
    set_nodes(5);
    push_edge(4, 5, 100, 1'b0, 1'b0);
    push_edge(1, 2, 10, 1'b0, 1'b0);
    push_edge(2, 1, 3, 1'b0, 1'b1);
    wait_idle();
    set_nodes(0);
    push_edge(0, 0, 1, 1'b0, 1'b1);
    wait_idle();
    set_nodes(1);
    push_edge(0, 0, 5, 1'b0, 1'b0);
    push_edge(0, 1, 5, 1'b0, 1'b1);
    wait_idle();

    // random phases
    total = 0;
    for (ph = 0; ph < 8; ph++) begin
      n = (ph == 4) ? $urandom_range(1, 300) : counts[ph];
      set_nodes(n);
      if (ph == 1) begin
        @(posedge clk);
        hold_go = 1'b1;
      end
      if (ph == 7) calm = 1'b1;
      i = 0;
      while (i < 52) begin
        n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 24);
        random_graph(n);
        i += n + 1;
      end
      total += i;
      wait_idle();
    end

    if (!failed) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
`default_nettype wire
